[src/websocket_client_frame_deframer_defines.svh]
// Assertion macros used by the deframer checker
`ifndef WEBSOCKET_CLIENT_FRAME_DEFRAMER_DEFINES_SVH
`define WEBSOCKET_CLIENT_FRAME_DEFRAMER_DEFINES_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define WSCFD_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while arst_n is low
`define WSCFD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[src/wscfd_pkg.sv]
// Types and constants of the WebSocket client frame deframer
package wscfd_pkg;

	localparam logic [15:0] MAX_PAYLOAD_RST = 16'd512;

	localparam logic [6:0] LEN_EXT16 = 7'd126;
	localparam logic [6:0] LEN_EXT64 = 7'd127;
	localparam logic [15:0] MASK_KEY_BYTES = 16'd4;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QFILL_W = QPTR_W + 1;

	localparam logic KIND_PAYLOAD = 1'b0;
	localparam logic KIND_STATUS = 1'b1;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_INCOMPLETE = 2'd1,
		ST_UNSUPPORTED = 2'd2,
		ST_TOO_LARGE = 2'd3
	} status_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic end_of_buffer;
	} in_item_t;

	typedef struct packed {
		logic result_kind;
		logic [7:0] payload_byte;
		logic [3:0] frame_opcode;
		logic [15:0] frame_length;
		logic [1:0] frame_status;
		logic last_result;
	} out_item_t;

endpackage

[src/websocket_client_frame_deframer.sv]
// Top level: WebSocket client frame header parser and payload unmasker
// Takes one buffer byte per transfer and returns the unmasked payload bytes followed, on the
// byte flagged end_of_buffer, by one status result (opcode, length, ok / incomplete /
// 64-bit length / too large); the parser then starts over for the next buffer. Each byte is
// parsed in the cycle it is accepted and its results are registered into the result queue.
// The input takes one byte per cycle while the four-entry result queue has two free slots:
// a buffer's last byte that is also a payload byte gives two results and so takes up two
// queue slots, otherwise throughput is one byte per cycle. Results of a non-ok status
// carry length 0, and payload already sent for such a frame should be dropped downstream.
module websocket_client_frame_deframer (
	input logic clk,
	input logic arst_n,
	input logic cfg_write,
	input logic [15:0] cfg_data,
	input logic in_valid,
	output logic in_stall,
	input wscfd_pkg::in_item_t in_item,
	output logic out_valid,
	input logic out_stall,
	output wscfd_pkg::out_item_t out_item
);

	typedef enum logic [6:0] {
		PH_HDR0 = 7'b0000001,
		PH_HDR1 = 7'b0000010,
		PH_EXTHI = 7'b0000100,
		PH_EXTLO = 7'b0001000,
		PH_MASK = 7'b0010000,
		PH_PAY = 7'b0100000,
		PH_DONE = 7'b1000000
	} phase_t;

	phase_t phase_q, phase_n;
	logic [3:0] opcode_q, opcode_n;
	logic mask_on_q, mask_on_n;
	logic [15:0] length_q, length_n;
	logic [31:0] key_q, key_n;
	logic [15:0] count_q, count_n;
	wscfd_pkg::status_t error_q, error_n;
	logic [15:0] max_payload_q;

	wscfd_pkg::out_item_t queue_q [wscfd_pkg::QDEPTH];
	logic [wscfd_pkg::QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [wscfd_pkg::QFILL_W-1:0] fill_q;

	logic accept, pop, len_known, pay_push;
	logic [7:0] key_byte;
	logic [1:0] push_cnt;
	wscfd_pkg::out_item_t pay_res, stat_res, entry0;

	assign accept = in_valid && !in_stall;
	assign pop = out_valid && !out_stall;
	assign in_stall = fill_q > wscfd_pkg::QFILL_W'(wscfd_pkg::QDEPTH - 2);
	assign out_valid = fill_q != '0;
	assign out_item = queue_q[rd_ptr_q];

	always_comb begin
		unique case (count_q[1:0])
			2'd0: key_byte = key_q[31:24];
			2'd1: key_byte = key_q[23:16];
			2'd2: key_byte = key_q[15:8];
			2'd3: key_byte = key_q[7:0];
			default: key_byte = '0;
		endcase
	end

	always_comb begin
		phase_n = phase_q;
		opcode_n = opcode_q;
		mask_on_n = mask_on_q;
		length_n = length_q;
		key_n = key_q;
		count_n = count_q;
		error_n = error_q;
		len_known = 1'b0;
		pay_push = 1'b0;
		unique case (phase_q)
			PH_HDR0: begin
				opcode_n = in_item.data_byte[3:0];
				phase_n = PH_HDR1;
			end
			PH_HDR1: begin
				mask_on_n = in_item.data_byte[7];
				key_n = '0;
				if (in_item.data_byte[6:0] == wscfd_pkg::LEN_EXT64) begin
					error_n = wscfd_pkg::ST_UNSUPPORTED;
					phase_n = PH_DONE;
				end else if (in_item.data_byte[6:0] == wscfd_pkg::LEN_EXT16) begin
					phase_n = PH_EXTHI;
				end else begin
					length_n = {9'd0, in_item.data_byte[6:0]};
					len_known = 1'b1;
				end
			end
			PH_EXTHI: begin
				length_n = {in_item.data_byte, 8'h00};
				phase_n = PH_EXTLO;
			end
			PH_EXTLO: begin
				length_n = {length_q[15:8], in_item.data_byte};
				len_known = 1'b1;
			end
			PH_MASK: begin
				key_n = {key_q[23:0], in_item.data_byte};
				count_n = count_q + 16'd1;
				if (count_n >= wscfd_pkg::MASK_KEY_BYTES) begin
					count_n = '0;
					phase_n = (length_q == '0) ? PH_DONE : PH_PAY;
				end
			end
			PH_PAY: begin
				count_n = count_q + 16'd1;
				pay_push = 1'b1;
				if (count_n >= length_q) begin
					phase_n = PH_DONE;
				end
			end
			PH_DONE: begin
				phase_n = PH_DONE;
			end
			default: begin
				phase_n = PH_DONE;
			end
		endcase

		if (len_known) begin
			count_n = '0;
			if (length_n > max_payload_q) begin
				error_n = wscfd_pkg::ST_TOO_LARGE;
				phase_n = PH_DONE;
			end else if (mask_on_n) begin
				phase_n = PH_MASK;
			end else if (length_n == '0) begin
				phase_n = PH_DONE;
			end else begin
				phase_n = PH_PAY;
			end
		end
	end

	always_comb begin
		pay_res = '0;
		pay_res.result_kind = wscfd_pkg::KIND_PAYLOAD;
		pay_res.payload_byte = in_item.data_byte ^ key_byte;

		stat_res = '0;
		stat_res.result_kind = wscfd_pkg::KIND_STATUS;
		stat_res.last_result = 1'b1;
		stat_res.frame_opcode = (phase_n == PH_HDR1) ? 4'd0 : opcode_n;
		if (error_n != wscfd_pkg::ST_OK) begin
			stat_res.frame_status = error_n;
		end else if (phase_n == PH_DONE) begin
			stat_res.frame_status = wscfd_pkg::ST_OK;
			stat_res.frame_length = length_n;
		end else begin
			stat_res.frame_status = wscfd_pkg::ST_INCOMPLETE;
		end

		entry0 = pay_push ? pay_res : stat_res;
		push_cnt = accept ? ({1'b0, pay_push} + {1'b0, in_item.end_of_buffer}) : 2'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_payload_q <= wscfd_pkg::MAX_PAYLOAD_RST;
		end else if (cfg_write) begin
			max_payload_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HDR0;
			opcode_q <= '0;
			mask_on_q <= 1'b0;
			length_q <= '0;
			key_q <= '0;
			count_q <= '0;
			error_q <= wscfd_pkg::ST_OK;
		end else if (accept) begin
			if (in_item.end_of_buffer) begin
				phase_q <= PH_HDR0;
				opcode_q <= '0;
				mask_on_q <= 1'b0;
				length_q <= '0;
				key_q <= '0;
				count_q <= '0;
				error_q <= wscfd_pkg::ST_OK;
			end else begin
				phase_q <= phase_n;
				opcode_q <= opcode_n;
				mask_on_q <= mask_on_n;
				length_q <= length_n;
				key_q <= key_n;
				count_q <= count_n;
				error_q <= error_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push_cnt != 2'd0) begin
			queue_q[wr_ptr_q] <= entry0;
		end
		if (push_cnt == 2'd2) begin
			queue_q[wr_ptr_q + wscfd_pkg::QPTR_W'(1)] <= stat_res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + wscfd_pkg::QPTR_W'(push_cnt);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + wscfd_pkg::QPTR_W'(1);
			end
			fill_q <= fill_q + wscfd_pkg::QFILL_W'(push_cnt) - wscfd_pkg::QFILL_W'(pop);
		end
	end

endmodule

[src/wscfd_checker.sv]
// Port-level checker for the WebSocket client frame deframer, with its bind
`include "websocket_client_frame_deframer_defines.svh"

module wscfd_checker (
	input logic clk,
	input logic arst_n,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall,
	input wscfd_pkg::out_item_t out_item
);

	logic pay_out, stat_out, pay_clean, stat_clean, stat_bad, stat_no_len, out_held;

	assign pay_out = out_valid && out_item.result_kind == wscfd_pkg::KIND_PAYLOAD;
	assign stat_out = out_valid && out_item.result_kind == wscfd_pkg::KIND_STATUS;
	assign pay_clean = !out_item.last_result && out_item.frame_opcode == '0
		&& out_item.frame_length == '0 && out_item.frame_status == wscfd_pkg::ST_OK;
	assign stat_clean = out_item.last_result && out_item.payload_byte == '0;
	assign stat_bad = stat_out && out_item.frame_status != wscfd_pkg::ST_OK;
	assign stat_no_len = out_item.frame_length == '0;
	assign out_held = out_valid && out_stall;

	`WSCFD_ASSERT_NOW(a_payload_fields, pay_out, pay_clean, "payload transfer carries status fields")
	`WSCFD_ASSERT_NOW(a_status_last, stat_out, stat_clean, "status transfer not marked last")
	`WSCFD_ASSERT_NOW(a_bad_status_len, stat_bad, stat_no_len, "rejected frame reports a length")
	`WSCFD_ASSERT_NOW(a_stall_has_output, in_stall, out_valid, "input held while no result pending")
	`WSCFD_ASSERT_NEXT(a_out_hold, out_held, out_valid && $stable(out_item), "stalled result changed")

endmodule

bind websocket_client_frame_deframer wscfd_checker u_wscfd_checker (.*);
